>>> rtl/mmio_range_table_with_hint_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the range table
// Shared forms of the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef MMIO_RANGE_TABLE_WITH_HINT_UNIT_ASSERT_SVH
`define MMIO_RANGE_TABLE_WITH_HINT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MRTU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("range table check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MRTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("range table check failed");

`endif

>>> rtl/mrtu_pkg.sv
// ---------------------------------------------------------------------------
// Range table package
// Widths, request and status codes, and the structs passed along the cells.
// ---------------------------------------------------------------------------
package mrtu_pkg;

  localparam int PrimaryEntries  = 16;
  localparam int FallbackEntries = 4;
  localparam int NumCpu          = 4;
  localparam int HandleBits      = 16;

  localparam int AddrW   = 64;
  localparam int HandleW = 16;
  localparam int CpuW    = 2;
  localparam int BytesW  = 4;

  typedef enum logic [1:0] {
    ReqLookup,
    ReqRegPrimary,
    ReqRegFallback,
    ReqUnregister
  } req_e;

  typedef enum logic [2:0] {
    StOk,
    StNotFound,
    StOverlap,
    StFull,
    StBadSize
  } status_e;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_cmd_t;

  typedef struct packed {
    logic free_seen;
    logic ovl_any;
    logic hit_any;
  } chain_t;

endpackage

>>> rtl/mrtu_cell.sv
// ---------------------------------------------------------------------------
// Range table cell
// One table slot: range, owner and valid bit, with registered compare flags.
// ---------------------------------------------------------------------------
module mrtu_cell #(
  parameter int HANDLE_BITS = mrtu_pkg::HandleBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mrtu_pkg::cell_cmd_t         cmd_i,
  input  logic [mrtu_pkg::AddrW-1:0]  addr_i,
  input  logic [mrtu_pkg::AddrW-1:0]  last_i,
  input  logic [HANDLE_BITS-1:0]      wr_owner_i,
  input  mrtu_pkg::chain_t            link_i,
  input  logic [HANDLE_BITS-1:0]      owner_i,
  output mrtu_pkg::chain_t            link_o,
  output logic [HANDLE_BITS-1:0]      owner_o,
  output logic                        hit_o
);

  logic                       valid_q;
  logic                       hit_q;
  logic                       ovl_q;
  logic [mrtu_pkg::AddrW-1:0] base_q;
  logic [mrtu_pkg::AddrW-1:0] last_q;
  logic [HANDLE_BITS-1:0]     owner_q;
  logic                       in_rng;
  logic                       ovl;
  logic                       first_free;

  always_comb begin
    in_rng     = valid_q && (addr_i >= base_q) && (addr_i <= last_q);
    ovl        = valid_q && (addr_i <= last_q) && (base_q <= last_i);
    first_free = !valid_q && !link_i.free_seen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      ovl_q   <= 1'b0;
    end else begin
      if (cmd_i.cmp) begin
        hit_q <= in_rng;
        ovl_q <= ovl;
      end
      if (cmd_i.ins && first_free) begin
        valid_q <= 1'b1;
      end else if (cmd_i.del && hit_q) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && first_free) begin
      base_q  <= addr_i;
      last_q  <= last_i;
      owner_q <= wr_owner_i;
    end
  end

  always_comb begin
    link_o.free_seen = link_i.free_seen | !valid_q;
    link_o.ovl_any   = link_i.ovl_any | ovl_q;
    link_o.hit_any   = link_i.hit_any | hit_q;
    owner_o          = owner_i | (hit_q ? owner_q : '0);
    hit_o            = hit_q;
  end

endmodule

>>> rtl/mrtu_chain.sv
// ---------------------------------------------------------------------------
// Range table chain
// A row of cells forming one table; flags and owner pass from cell to cell.
// ---------------------------------------------------------------------------
module mrtu_chain #(
  parameter int ENTRIES     = mrtu_pkg::PrimaryEntries,
  parameter int HANDLE_BITS = mrtu_pkg::HandleBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mrtu_pkg::cell_cmd_t         cmd_i,
  input  logic [mrtu_pkg::AddrW-1:0]  addr_i,
  input  logic [mrtu_pkg::AddrW-1:0]  last_i,
  input  logic [HANDLE_BITS-1:0]      wr_owner_i,
  output mrtu_pkg::chain_t            link_o,
  output logic [HANDLE_BITS-1:0]      owner_o,
  output logic [ENTRIES-1:0]          hit_vec_o
);

  mrtu_pkg::chain_t       link  [ENTRIES+1];
  logic [HANDLE_BITS-1:0] owner [ENTRIES+1];

  assign link[0]  = '0;
  assign owner[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mrtu_cell #(
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .addr_i     (addr_i),
      .last_i     (last_i),
      .wr_owner_i (wr_owner_i),
      .link_i     (link[i]),
      .owner_i    (owner[i]),
      .link_o     (link[i+1]),
      .owner_o    (owner[i+1]),
      .hit_o      (hit_vec_o[i])
    );
  end

  assign link_o  = link[ENTRIES];
  assign owner_o = owner[ENTRIES];

endmodule

>>> rtl/mmio_range_table_with_hint_unit.sv
// ---------------------------------------------------------------------------
// Address range table with lookup hint
// Primary and fallback range tables built as rows of cells, plus a hint of
// the last primary hit for each requester.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake                 Word
//   in       input      in_valid_i / in_stall_o    request and access fields
//   out      output     out_valid_o / out_stall_i  status, handle and access
//
// Each word first has every cell's range compares registered (SCmp); SDone then
// picks the result, updates the tables and hints and loads the output.
// The next word is taken at the edge that loads the result.
// Reset clears the valid bits and the hints at once; there is no sweep.
// A result still stalled at the output holds the next word in SDone until it is taken.
// ---------------------------------------------------------------------------
module mmio_range_table_with_hint_unit #(
  parameter int PRIMARY_ENTRIES  = mrtu_pkg::PrimaryEntries,
  parameter int FALLBACK_ENTRIES = mrtu_pkg::FallbackEntries,
  parameter int NUM_CPU          = mrtu_pkg::NumCpu,
  parameter int HANDLE_BITS      = mrtu_pkg::HandleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [mrtu_pkg::AddrW-1:0]    address_i,
  input  logic [mrtu_pkg::AddrW-1:0]    range_size_i,
  input  logic [mrtu_pkg::HandleW-1:0]  handle_i,
  input  logic [mrtu_pkg::CpuW-1:0]     cpu_index_i,
  input  logic                          is_write_i,
  input  logic [mrtu_pkg::BytesW-1:0]   access_len_i,
  input  logic [mrtu_pkg::AddrW-1:0]    write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [mrtu_pkg::HandleW-1:0]  found_handle_o,
  output logic                          from_fallback_o,
  output logic                          hint_hit_o,
  output logic [mrtu_pkg::AddrW-1:0]    access_address_o,
  output logic                          access_is_write_o,
  output logic [mrtu_pkg::BytesW-1:0]   access_bytes_o,
  output logic [mrtu_pkg::AddrW-1:0]    access_data_o
);

  localparam int HintW   = $clog2(PRIMARY_ENTRIES + 1);
  localparam int SlotW   = (PRIMARY_ENTRIES > 1) ? $clog2(PRIMARY_ENTRIES) : 1;
  localparam int CpuSelW = ($clog2(NUM_CPU + 1) > 2) ? $clog2(NUM_CPU + 1) : 2;
  localparam int AW      = mrtu_pkg::AddrW;

  typedef enum logic [1:0] {
    SIdle,
    SCmp,
    SDone
  } state_e;

  state_e                        state_q;
  logic                          out_valid_q;
  mrtu_pkg::status_e             status_q;
  logic [mrtu_pkg::HandleW-1:0]  found_q;
  logic                          fb_q;
  logic                          hh_q;
  logic [AW-1:0]                 acc_addr_q;
  logic                          acc_wr_q;
  logic [mrtu_pkg::BytesW-1:0]   acc_bytes_q;
  logic [AW-1:0]                 acc_data_q;
  logic [HintW-1:0]              hint_q [NUM_CPU];

  mrtu_pkg::req_e                req_q;
  logic [AW-1:0]                 addr_q;
  logic [AW-1:0]                 last_q;
  logic                          bad_q;
  logic [HANDLE_BITS-1:0]        handle_q;
  logic [mrtu_pkg::CpuW-1:0]     cpu_q;
  logic                          wr_q;
  logic [mrtu_pkg::BytesW-1:0]   bytes_q;
  logic [AW-1:0]                 data_q;

  logic [AW:0]                   sum_end;
  logic                          out_free;
  logic                          done_fire;
  logic                          in_accept;

  mrtu_pkg::cell_cmd_t           p_cmd;
  mrtu_pkg::cell_cmd_t           f_cmd;
  mrtu_pkg::chain_t              p_link;
  mrtu_pkg::chain_t              f_link;
  logic [HANDLE_BITS-1:0]        p_owner;
  logic [HANDLE_BITS-1:0]        f_owner;
  logic [PRIMARY_ENTRIES-1:0]    p_hit_vec;
  logic [FALLBACK_ENTRIES-1:0]   f_hit_vec;

  logic [CpuSelW-1:0]            cpu_sel;
  logic                          cpu_ok;
  logic [HintW-1:0]              hint_cur;
  logic                          hint_ok;
  logic [SlotW-1:0]              p_slot;
  logic [NUM_CPU-1:0]            hint_names;

  mrtu_pkg::status_e             status_d;
  logic [mrtu_pkg::HandleW-1:0]  found_d;
  logic                          fb_d;
  logic                          hh_d;
  logic [AW-1:0]                 acc_addr_d;
  logic                          acc_wr_d;
  logic [mrtu_pkg::BytesW-1:0]   acc_bytes_d;
  logic [AW-1:0]                 acc_data_d;
  logic                          p_ins;
  logic                          f_ins;
  logic                          p_del;
  logic                          hint_wr;
  logic                          hint_clr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign done_fire  = (state_q == SDone) && out_free;
  assign in_stall_o = !((state_q == SIdle) || done_fire);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sum_end = {1'b0, address_i} + {1'b0, range_size_i} - {{AW{1'b0}}, 1'b1};

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= mrtu_pkg::req_e'(req_type_i);
      addr_q   <= address_i;
      last_q   <= sum_end[AW-1:0];
      bad_q    <= (range_size_i == '0) || sum_end[AW];
      handle_q <= HANDLE_BITS'(handle_i);
      cpu_q    <= cpu_index_i;
      wr_q     <= is_write_i;
      bytes_q  <= access_len_i;
      data_q   <= write_data_i;
    end
  end

  mrtu_chain #(
    .ENTRIES     (PRIMARY_ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_primary (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (p_cmd),
    .addr_i     (addr_q),
    .last_i     (last_q),
    .wr_owner_i (handle_q),
    .link_o     (p_link),
    .owner_o    (p_owner),
    .hit_vec_o  (p_hit_vec)
  );

  mrtu_chain #(
    .ENTRIES     (FALLBACK_ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_fallback (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (f_cmd),
    .addr_i     (addr_q),
    .last_i     (last_q),
    .wr_owner_i (handle_q),
    .link_o     (f_link),
    .owner_o    (f_owner),
    .hit_vec_o  (f_hit_vec)
  );

  // Primary ranges never overlap, so at most one slot can hit.
  always_comb begin
    cpu_sel  = CpuSelW'(cpu_q);
    cpu_ok   = cpu_sel < CpuSelW'(NUM_CPU);
    hint_cur = '0;
    for (int k = 0; k < NUM_CPU; k++) begin
      if (cpu_sel == CpuSelW'(k)) begin
        hint_cur = hint_q[k];
      end
    end
    hint_ok = cpu_ok && (hint_cur != '0) && (hint_cur <= HintW'(PRIMARY_ENTRIES)) &&
              p_hit_vec[SlotW'(hint_cur - HintW'(1))];
    p_slot = '0;
    for (int i = 0; i < PRIMARY_ENTRIES; i++) begin
      if (p_hit_vec[i]) begin
        p_slot = p_slot | SlotW'(i);
      end
    end
    for (int k = 0; k < NUM_CPU; k++) begin
      hint_names[k] = (hint_q[k] != '0) && (hint_q[k] <= HintW'(PRIMARY_ENTRIES)) &&
                      p_hit_vec[SlotW'(hint_q[k] - HintW'(1))];
    end
  end

  always_comb begin
    status_d    = mrtu_pkg::StNotFound;
    found_d     = '0;
    fb_d        = 1'b0;
    hh_d        = 1'b0;
    acc_addr_d  = '0;
    acc_wr_d    = 1'b0;
    acc_bytes_d = '0;
    acc_data_d  = '0;
    p_ins       = 1'b0;
    f_ins       = 1'b0;
    p_del       = 1'b0;
    hint_wr     = 1'b0;
    hint_clr    = 1'b0;
    case (req_q)
      mrtu_pkg::ReqLookup: begin
        if (p_link.hit_any || f_link.hit_any) begin
          status_d    = mrtu_pkg::StOk;
          found_d     = mrtu_pkg::HandleW'(p_link.hit_any ? p_owner : f_owner);
          fb_d        = !p_link.hit_any;
          hh_d        = p_link.hit_any && hint_ok;
          acc_addr_d  = addr_q;
          acc_wr_d    = wr_q;
          acc_bytes_d = bytes_q;
          acc_data_d  = data_q;
        end
        hint_wr = p_link.hit_any && cpu_ok && !hint_ok;
      end
      mrtu_pkg::ReqRegPrimary: begin
        if (bad_q) begin
          status_d = mrtu_pkg::StBadSize;
        end else if (p_link.hit_any) begin
          status_d = mrtu_pkg::StOk;
        end else if (p_link.ovl_any) begin
          status_d = mrtu_pkg::StOverlap;
        end else if (!p_link.free_seen) begin
          status_d = mrtu_pkg::StFull;
        end else begin
          status_d = mrtu_pkg::StOk;
          p_ins    = 1'b1;
        end
      end
      mrtu_pkg::ReqRegFallback: begin
        if (bad_q) begin
          status_d = mrtu_pkg::StBadSize;
        end else if (f_link.hit_any) begin
          status_d = mrtu_pkg::StOk;
        end else if (f_link.ovl_any) begin
          status_d = mrtu_pkg::StOverlap;
        end else if (!f_link.free_seen) begin
          status_d = mrtu_pkg::StFull;
        end else begin
          status_d = mrtu_pkg::StOk;
          f_ins    = 1'b1;
        end
      end
      mrtu_pkg::ReqUnregister: begin
        if (p_link.hit_any) begin
          status_d = mrtu_pkg::StOk;
          p_del    = 1'b1;
          hint_clr = 1'b1;
        end
      end
      default: begin
        status_d = mrtu_pkg::StNotFound;
      end
    endcase
  end

  always_comb begin
    p_cmd.cmp = (state_q == SCmp);
    p_cmd.ins = done_fire && p_ins;
    p_cmd.del = done_fire && p_del;
    f_cmd.cmp = (state_q == SCmp);
    f_cmd.ins = done_fire && f_ins;
    f_cmd.del = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      status_q    <= mrtu_pkg::StOk;
      found_q     <= '0;
      fb_q        <= 1'b0;
      hh_q        <= 1'b0;
      acc_addr_q  <= '0;
      acc_wr_q    <= 1'b0;
      acc_bytes_q <= '0;
      acc_data_q  <= '0;
      for (int k = 0; k < NUM_CPU; k++) begin
        hint_q[k] <= '0;
      end
    end else begin
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            state_q <= SCmp;
          end
        end
        SCmp: begin
          state_q <= SDone;
        end
        SDone: begin
          if (out_free) begin
            state_q <= in_valid_i ? SCmp : SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
      if (done_fire) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        found_q     <= found_d;
        fb_q        <= fb_d;
        hh_q        <= hh_d;
        acc_addr_q  <= acc_addr_d;
        acc_wr_q    <= acc_wr_d;
        acc_bytes_q <= acc_bytes_d;
        acc_data_q  <= acc_data_d;
        for (int k = 0; k < NUM_CPU; k++) begin
          if (hint_wr && (cpu_sel == CpuSelW'(k))) begin
            hint_q[k] <= HintW'(p_slot) + HintW'(1);
          end else if (hint_clr && hint_names[k]) begin
            hint_q[k] <= '0;
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign found_handle_o    = found_q;
  assign from_fallback_o   = fb_q;
  assign hint_hit_o        = hh_q;
  assign access_address_o  = acc_addr_q;
  assign access_is_write_o = acc_wr_q;
  assign access_bytes_o    = acc_bytes_q;
  assign access_data_o     = acc_data_q;

endmodule

>>> rtl/mrtu_checker.sv
// ---------------------------------------------------------------------------
// Range table port checker
// Checks on the top level's ports over time, bound to the top level.
// ---------------------------------------------------------------------------
`include "mmio_range_table_with_hint_unit_assert.svh"

module mrtu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [2:0]                    status_o,
  input logic [mrtu_pkg::HandleW-1:0]  found_handle_o,
  input logic                          from_fallback_o,
  input logic                          hint_hit_o,
  input logic [mrtu_pkg::AddrW-1:0]    access_address_o,
  input logic                          access_is_write_o,
  input logic [mrtu_pkg::BytesW-1:0]   access_bytes_o,
  input logic [mrtu_pkg::AddrW-1:0]    access_data_o
);

  logic in_fire;
  logic res_clear;
  logic not_ok;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign not_ok    = status_o != mrtu_pkg::StOk;
  assign res_clear = (found_handle_o == '0) && !from_fallback_o && !hint_hit_o &&
                     (access_address_o == '0) && !access_is_write_o &&
                     (access_bytes_o == '0) && (access_data_o == '0);

  `MRTU_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `MRTU_ASSERT_NEXT(a_one_word_busy, clk_i, rst_ni, in_fire, in_stall_o)
  `MRTU_ASSERT_NOW(a_fresh_result, clk_i, rst_ni, $rose(out_valid_o), $past(in_fire, 3))
  `MRTU_ASSERT_NOW(a_miss_zeroed, clk_i, rst_ni, out_valid_o && not_ok, res_clear)
  `MRTU_ASSERT_NOW(a_hint_primary, clk_i, rst_ni, out_valid_o && hint_hit_o, !not_ok && !from_fallback_o)

endmodule

bind mmio_range_table_with_hint_unit mrtu_checker u_mrtu_checker (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Range table with lookup hint: self-checking testbench
// A driver offers request words from a queue and keeps its own copy of both
// range tables and the hints to predict every result. A monitor compares
// each result word with the oldest prediction, while both sides idle at
// random and the receiver once holds off long enough to back up the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 250;
  localparam int DrainCycles   = 16;
  localparam int ReportLimit   = 10;

  typedef struct packed {
    mrtu_pkg::req_e req;
    logic [63:0]    address;
    logic [63:0]    range_size;
    logic [15:0]    handle;
    logic [1:0]     cpu;
    logic           is_write;
    logic [3:0]     access_len;
    logic [63:0]    write_data;
  } access_req_t;

  typedef struct packed {
    mrtu_pkg::status_e status;
    logic [15:0]       found_handle;
    logic              from_fallback;
    logic              hint_hit;
    logic [63:0]       access_address;
    logic              access_is_write;
    logic [3:0]        access_bytes;
    logic [63:0]       access_data;
  } decode_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [63:0] address_i = '0;
  logic [63:0] range_size_i = '0;
  logic [15:0] handle_i = '0;
  logic [1:0]  cpu_index_i = '0;
  logic        is_write_i = 1'b0;
  logic [3:0]  access_len_i = '0;
  logic [63:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] found_handle_o;
  logic        from_fallback_o;
  logic        hint_hit_o;
  logic [63:0] access_address_o;
  logic        access_is_write_o;
  logic [3:0]  access_bytes_o;
  logic [63:0] access_data_o;

  mmio_range_table_with_hint_unit dut (.*);

  // Table 0 is the primary table, table 1 the fallback table.
  logic [63:0] rng_base  [2][mrtu_pkg::PrimaryEntries];
  logic [63:0] rng_end   [2][mrtu_pkg::PrimaryEntries];
  logic [15:0] rng_owner [2][mrtu_pkg::PrimaryEntries];
  bit          rng_valid [2][mrtu_pkg::PrimaryEntries];
  logic [4:0]  cpu_hint  [mrtu_pkg::NumCpu];

  access_req_t pending_reqs[$];
  decode_res_t expected_decodes[$];
  logic [63:0] recent_bases[$];

  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  bit pressure_armed    = 1'b0;
  bit hold_done         = 1'b0;
  int hold_left         = 0;
  int idle_cycles       = 0;
  int fault_count       = 0;
  int words_taken       = 0;
  int hint_tally        = 0;
  int fallback_tally    = 0;
  int status_tally[5];

  always #5 clk_i = ~clk_i;

  function automatic int slots(input int t);
    return (t == 0) ? mrtu_pkg::PrimaryEntries : mrtu_pkg::FallbackEntries;
  endfunction

  function automatic int find_range(input int t, input logic [63:0] a);
    for (int i = 0; i < slots(t); i++) begin
      if (rng_valid[t][i] && a >= rng_base[t][i] && a <= rng_end[t][i]) return i;
    end
    return -1;
  endfunction

  function automatic mrtu_pkg::status_e insert_range(input int t, input access_req_t r);
    logic [63:0] last;
    int free_slot;
    if (r.range_size == 0 || r.range_size - 1 > ~r.address) return mrtu_pkg::StBadSize;
    last = r.address + (r.range_size - 1);
    if (find_range(t, r.address) >= 0) return mrtu_pkg::StOk;
    free_slot = -1;
    for (int i = 0; i < slots(t); i++) begin
      if (rng_valid[t][i]) begin
        if (r.address <= rng_end[t][i] && rng_base[t][i] <= last) begin
          return mrtu_pkg::StOverlap;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot < 0) return mrtu_pkg::StFull;
    rng_base[t][free_slot]  = r.address;
    rng_end[t][free_slot]   = last;
    rng_owner[t][free_slot] = r.handle;
    rng_valid[t][free_slot] = 1'b1;
    return mrtu_pkg::StOk;
  endfunction

  function automatic decode_res_t decode_request(input access_req_t r);
    decode_res_t d;
    int slot;
    int hinted;
    bit hit;
    d = '0;
    d.status = mrtu_pkg::StNotFound;
    hit = 1'b0;
    case (r.req)
      mrtu_pkg::ReqLookup: begin
        hinted = (r.cpu < mrtu_pkg::NumCpu) ? int'(cpu_hint[r.cpu]) - 1 : -1;
        if (hinted >= 0 && hinted < mrtu_pkg::PrimaryEntries && rng_valid[0][hinted] &&
            r.address >= rng_base[0][hinted] && r.address <= rng_end[0][hinted]) begin
          hit = 1'b1;
          d.hint_hit = 1'b1;
          d.found_handle = rng_owner[0][hinted];
        end else begin
          slot = find_range(0, r.address);
          if (slot >= 0) begin
            hit = 1'b1;
            d.found_handle = rng_owner[0][slot];
            if (r.cpu < mrtu_pkg::NumCpu) cpu_hint[r.cpu] = 5'(slot + 1);
          end else begin
            slot = find_range(1, r.address);
            if (slot >= 0) begin
              hit = 1'b1;
              d.from_fallback = 1'b1;
              d.found_handle = rng_owner[1][slot];
            end
          end
        end
        if (hit) begin
          d.status = mrtu_pkg::StOk;
          d.access_address = r.address;
          d.access_is_write = r.is_write;
          d.access_bytes = r.access_len;
          d.access_data = r.write_data;
        end else begin
          d.found_handle = '0;
        end
      end
      mrtu_pkg::ReqRegPrimary: d.status = insert_range(0, r);
      mrtu_pkg::ReqRegFallback: d.status = insert_range(1, r);
      default: begin
        slot = find_range(0, r.address);
        if (slot >= 0) begin
          rng_valid[0][slot] = 1'b0;
          for (int k = 0; k < mrtu_pkg::NumCpu; k++) begin
            if (cpu_hint[k] == 5'(slot + 1)) cpu_hint[k] = '0;
          end
          d.status = mrtu_pkg::StOk;
        end
      end
    endcase
    return d;
  endfunction

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= ReportLimit) $display("%t: %s", $realtime, what);
  endtask

  // Driver: holds a word until it is taken, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    access_req_t nxt;
    bit busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_decodes.push_back(decode_request(pending_reqs.pop_front()));
        words_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = pending_reqs[0];
          in_valid_i     <= 1'b1;
          req_type_i     <= nxt.req;
          address_i      <= nxt.address;
          range_size_i   <= nxt.range_size;
          handle_i       <= nxt.handle;
          cpu_index_i    <= nxt.cpu;
          is_write_i     <= nxt.is_write;
          access_len_i   <= nxt.access_len;
          write_data_i   <= nxt.write_data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once armed.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (pressure_armed && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    decode_res_t seen;
    decode_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.status          = mrtu_pkg::status_e'(status_o);
      seen.found_handle    = found_handle_o;
      seen.from_fallback   = from_fallback_o;
      seen.hint_hit        = hint_hit_o;
      seen.access_address  = access_address_o;
      seen.access_is_write = access_is_write_o;
      seen.access_bytes    = access_bytes_o;
      seen.access_data     = access_data_o;
      if (expected_decodes.size() == 0) begin
        report_fault("Result word arrived with no prediction outstanding.");
      end else begin
        want = expected_decodes.pop_front();
        if (want.status <= mrtu_pkg::StBadSize) status_tally[want.status]++;
        hint_tally += want.hint_hit;
        fallback_tally += want.from_fallback;
        if (seen.status !== want.status || seen.found_handle !== want.found_handle ||
            seen.from_fallback !== want.from_fallback || seen.hint_hit !== want.hint_hit ||
            seen.access_address !== want.access_address ||
            seen.access_is_write !== want.access_is_write ||
            seen.access_bytes !== want.access_bytes ||
            seen.access_data !== want.access_data) begin
          report_fault($sformatf(
            "Mismatch: exp st=%0d h=%h fb=%b hh=%b a=%h w=%b n=%h d=%h",
            want.status, want.found_handle, want.from_fallback, want.hint_hit,
            want.access_address, want.access_is_write, want.access_bytes,
            want.access_data));
          if (fault_count <= ReportLimit) begin
            $display("          got st=%0d h=%h fb=%b hh=%b a=%h w=%b n=%h d=%h",
                     status_o, found_handle_o, from_fallback_o, hint_hit_o,
                     access_address_o, access_is_write_o, access_bytes_o,
                     access_data_o);
          end
        end
      end
    end
  end

  // Watchdog: gives up when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d requests queued and %0d results due.",
                 pending_reqs.size(), expected_decodes.size());
        $display("[mmio_range_table_with_hint_unit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_req(input mrtu_pkg::req_e req, input logic [63:0] addr,
                          input logic [63:0] size, input logic [15:0] handle,
                          input logic [1:0] cpu, input logic wr,
                          input logic [3:0] width, input logic [63:0] data);
    access_req_t r;
    r = '{req, addr, size, handle, cpu, wr, width, data};
    pending_reqs.push_back(r);
  endtask

  function automatic access_req_t blank_req();
    access_req_t r;
    r.req          = mrtu_pkg::req_e'($urandom_range(0, 3));
    r.address      = {$urandom, $urandom};
    r.range_size   = {$urandom, $urandom};
    r.handle       = 16'($urandom);
    r.cpu          = 2'($urandom_range(0, 3));
    r.is_write     = 1'($urandom);
    r.access_len   = 4'($urandom_range(0, 15));
    r.write_data   = {$urandom, $urandom};
    return r;
  endfunction

  function automatic logic [63:0] near_address();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 8191));
      1: return 64'h0000_1234_5678_0000 + $urandom_range(0, 8191);
      2: return 64'hFFFF_FFFF_FFFF_E000 + $urandom_range(0, 8191);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] known_address();
    if (recent_bases.size() == 0 || $urandom_range(0, 3) == 0) return near_address();
    return recent_bases[$urandom_range(0, recent_bases.size() - 1)];
  endfunction

  function automatic logic [63:0] random_size(input logic [63:0] b);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return {$urandom, $urandom};
    if (pick == 2) return (~b) + 64'd1;
    return 64'($urandom_range(1, 1024));
  endfunction

  task automatic queue_random_traffic(input int count);
    access_req_t r;
    access_req_t hit_req;
    logic [63:0] b;
    int unsigned kind;
    int pushed;
    pushed = 0;
    while (pushed < count) begin
      kind = $urandom_range(0, 99);
      r = blank_req();
      if (kind < 40) begin
        b = known_address();
        repeat ($urandom_range(2, 5)) begin
          hit_req = blank_req();
          hit_req.req = mrtu_pkg::ReqLookup;
          hit_req.cpu = r.cpu;
          hit_req.address = b + $urandom_range(0, 255);
          pending_reqs.push_back(hit_req);
          pushed++;
        end
      end else begin
        if (kind < 90) begin
          r.req = (kind < 65) ? mrtu_pkg::ReqRegPrimary :
                  (kind < 75) ? mrtu_pkg::ReqRegFallback : mrtu_pkg::ReqUnregister;
          if (r.req == mrtu_pkg::ReqUnregister) begin
            r.address = known_address() + ($urandom_range(0, 1) ? $urandom_range(0, 63) : 0);
          end else begin
            r.address = near_address();
            r.range_size = random_size(r.address);
            recent_bases.push_back(r.address);
            if (recent_bases.size() > 32) void'(recent_bases.pop_front());
          end
        end
        pending_reqs.push_back(r);
        pushed++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_decodes.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < mrtu_pkg::PrimaryEntries; i++) rng_valid[t][i] = 1'b0;
    end
    for (int k = 0; k < mrtu_pkg::NumCpu; k++) cpu_hint[k] = '0;
    for (int s = 0; s < 5; s++) status_tally[s] = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    sender_idle_pct = 19;
    receiver_stall_pct = 88;

    push_req(mrtu_pkg::ReqLookup, '0, '0, '0, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqUnregister, '0, '0, '0, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegPrimary, 64'h1000, '0, 16'h1111, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegPrimary, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 16'h2222,
             2'd1, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegPrimary, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 16'h3333,
             2'd1, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegPrimary, 64'h1000, 64'h100, 16'hFFFF, 2'd2, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegPrimary, 64'h1080, 64'h10, 16'h4444, 2'd2, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegPrimary, 64'h0F00, 64'h200, 16'h5555, 2'd3, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegFallback, 64'h1000, 64'h1000, 16'hA5A5, 2'd3, 1'b0, 4'd1,
             '0);
    push_req(mrtu_pkg::ReqLookup, 64'h1050, '1, '1, 2'd0, 1'b1, 4'd8, '1);
    push_req(mrtu_pkg::ReqLookup, 64'h10FF, '0, '0, 2'd0, 1'b0, 4'd1,
             64'h0123_4567_89AB_CDEF);
    push_req(mrtu_pkg::ReqLookup, 64'h1800, '0, '0, 2'd1, 1'b1, 4'd0,
             64'hDEAD_BEEF_0000_0001);
    push_req(mrtu_pkg::ReqLookup, '1, '0, '0, 2'd3, 1'b0, 4'd15, '1);
    push_req(mrtu_pkg::ReqLookup, '1, '0, '0, 2'd3, 1'b1, 4'd9, '0);
    push_req(mrtu_pkg::ReqUnregister, 64'h1010, '0, '0, 2'd2, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqLookup, 64'h1050, '0, '0, 2'd0, 1'b0, 4'd4,
             64'h5A5A_5A5A_5A5A_5A5A);
    push_req(mrtu_pkg::ReqRegPrimary, '0, '1, 16'h6666, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegFallback, 64'h10000, 64'h10, 16'h0001, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegFallback, 64'h20000, 64'h10, 16'h0002, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegFallback, 64'h30000, 64'h10, 16'h0003, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqRegFallback, 64'h40000, 64'h10, 16'h0004, 2'd0, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqLookup, 64'h3000F, '0, '0, 2'd2, 1'b1, 4'd2, '1);
    push_req(mrtu_pkg::ReqUnregister, '1, '0, '0, 2'd1, 1'b0, 4'd1, '0);
    push_req(mrtu_pkg::ReqLookup, '1, '0, '0, 2'd3, 1'b0, 4'd8, '0);
    queue_random_traffic(400);
    wait_drained();

    sender_idle_pct = 88;
    receiver_stall_pct = 19;
    queue_random_traffic(450);
    wait_drained();

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    queue_random_traffic(450);
    pressure_armed = 1'b1;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d requests: %0d ok, %0d not found, %0d overlap, %0d full, %0d bad size.",
             words_taken, status_tally[mrtu_pkg::StOk], status_tally[mrtu_pkg::StNotFound],
             status_tally[mrtu_pkg::StOverlap], status_tally[mrtu_pkg::StFull],
             status_tally[mrtu_pkg::StBadSize]);
    $display("Lookups served by a hint: %0d, by the fallback table: %0d; faults: %0d.",
             hint_tally, fallback_tally, fault_count);
    if (fault_count == 0) begin
      $display("[mmio_range_table_with_hint_unit] OK");
    end else begin
      $display("[mmio_range_table_with_hint_unit] ERROR");
    end
    $finish;
  end

endmodule
